/* src/magnetic_angle_sensor_word_decoder_top_defines.svh */
// Assertion helpers for the word decoder.
`ifndef MAGNETIC_ANGLE_SENSOR_WORD_DECODER_TOP_DEFINES_SVH
`define MAGNETIC_ANGLE_SENSOR_WORD_DECODER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/mas_pkg.sv */
package mas_pkg;

    localparam int WORD_W    = 16;
    localparam int ANGLE_W   = 10;
    localparam int MOVE_W    = 11;
    localparam int COUNT_W   = 32;

    // s_tuser codes
    localparam logic CMD_WORD          = 1'b0;
    localparam logic CMD_FRAMING_ERROR = 1'b1;

    localparam logic [7:0] VERSION_ONE = 8'd1;

    // Version 1 word classes
    localparam logic [15:0] V1_VER_MASK    = 16'h7F00;
    localparam logic [15:0] V1_VER_MATCH   = 16'h6000;
    localparam logic [15:0] V1_ERROR_WORD  = 16'h8000;
    localparam logic [15:0] V1_POS_MASK    = 16'hBC00;
    localparam logic [7:0]  V1_MIN_VERSION = 8'd2;

    // Message type, bits 14..13 of later protocol versions
    localparam logic [1:0] MSG_POSITION = 2'b00;
    localparam logic [1:0] MSG_ERROR    = 2'b01;
    localparam logic [1:0] MSG_INFO     = 2'b11;

    // Info word kind, bits 11..8
    localparam logic [3:0] INFO_VERSION   = 4'h0;
    localparam logic [3:0] INFO_MAGNITUDE = 4'h2;
    localparam logic [3:0] INFO_AGC       = 4'h3;

    localparam int SWITCH_BIT_V1 = 14;
    localparam int SWITCH_BIT_V2 = 12;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 10'd512;

    typedef struct packed {
        logic [WORD_W-1:0]  last_pos;
        logic [7:0]         version;
        logic               upgraded;
        logic               error_flag;
        logic [7:0]         error_code;
        logic               seen;
        logic [7:0]         magnitude;
        logic [7:0]         agc;
        logic [COUNT_W-1:0] parity_count;
        logic [COUNT_W-1:0] framing_count;
    } mas_state_t;

    localparam mas_state_t STATE_RESET = '{
        last_pos:      '0,
        version:       VERSION_ONE,
        upgraded:      1'b0,
        error_flag:    1'b0,
        error_code:    '0,
        seen:          1'b0,
        magnitude:     '0,
        agc:           '0,
        parity_count:  '0,
        framing_count: '0
    };

    typedef struct packed {
        logic                      position_valid;
        logic [ANGLE_W-1:0]        angle;
        logic signed [MOVE_W-1:0]  movement;
        logic                      sensor_error;
        logic [7:0]                error_code;
        logic                      filament_absent;
        logic                      data_received;
        logic [7:0]                version;
        logic [7:0]                magnitude;
        logic [7:0]                agc;
        logic [COUNT_W-1:0]        parity_errors;
        logic [COUNT_W-1:0]        framing_errors;
    } mas_result_t;

endpackage

/* src/mas_decode.sv */
module mas_decode (
    input  logic                        command,
    input  logic [mas_pkg::WORD_W-1:0]  word,
    input  logic                        switch_present,
    input  mas_pkg::mas_state_t         state,
    output mas_pkg::mas_state_t         state_next,
    output mas_pkg::mas_result_t        result
);
    import mas_pkg::*;

    logic                 parity_bad;
    logic [7:0]           low;
    logic                 pos;
    logic [ANGLE_W-1:0]   change;
    logic [MOVE_W-1:0]    movement;
    mas_state_t           nxt;

    assign parity_bad = ^word;
    assign low        = word[7:0];

    always_comb begin
        nxt = state;
        pos = 1'b0;
        if (command == CMD_FRAMING_ERROR) begin
            nxt.framing_count = state.framing_count + 32'd1;
        end else if (state.version == VERSION_ONE) begin
            if (!parity_bad && ((word & V1_VER_MASK) == V1_VER_MATCH)
                    && (low >= V1_MIN_VERSION)) begin
                nxt.version = low;
                if (switch_present) begin
                    nxt.upgraded = 1'b1;
                end
            end else if (word == V1_ERROR_WORD) begin
                nxt.error_flag = 1'b1;
                nxt.error_code = '0;
            end else if ((word & V1_POS_MASK) == '0) begin
                // version 1 takes position words regardless of parity
                pos            = 1'b1;
                nxt.error_flag = 1'b0;
                nxt.seen       = 1'b1;
            end
        end else if (parity_bad) begin
            nxt.parity_count = state.parity_count + 32'd1;
        end else begin
            case (word[14:13])
                MSG_POSITION: begin
                    pos            = 1'b1;
                    nxt.error_flag = 1'b0;
                    nxt.seen       = 1'b1;
                end
                MSG_ERROR: begin
                    nxt.error_code = low;
                    nxt.error_flag = (low != 8'd0);
                    nxt.seen       = 1'b1;
                end
                MSG_INFO: begin
                    case (word[11:8])
                        INFO_VERSION: begin
                            nxt.version = low;
                            nxt.seen    = 1'b1;
                        end
                        INFO_MAGNITUDE: nxt.magnitude = low;
                        INFO_AGC:       nxt.agc = low;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (pos) begin
            nxt.last_pos = word;
        end
    end

    // Wrap the change into -511..512: above half a turn it is a step backward.
    assign change = word[ANGLE_W-1:0] - state.last_pos[ANGLE_W-1:0];

    always_comb begin
        if (!pos) begin
            movement = '0;
        end else if (change <= HALF_TURN) begin
            movement = {1'b0, change};
        end else begin
            movement = {1'b1, change};
        end
    end

    assign state_next = nxt;

    always_comb begin
        result.position_valid  = pos;
        result.angle           = nxt.last_pos[ANGLE_W-1:0];
        result.movement        = movement;
        result.sensor_error    = nxt.error_flag;
        result.error_code      = nxt.error_code;
        result.filament_absent = switch_present &&
            (nxt.upgraded ? nxt.last_pos[SWITCH_BIT_V2] : nxt.last_pos[SWITCH_BIT_V1]);
        result.data_received   = nxt.seen;
        result.version         = nxt.version;
        result.magnitude       = nxt.magnitude;
        result.agc             = nxt.agc;
        result.parity_errors   = nxt.parity_count;
        result.framing_errors  = nxt.framing_count;
    end

endmodule

/* src/mas_state.sv */
module mas_state (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 update_en,
    input  mas_pkg::mas_state_t  state_next,
    output mas_pkg::mas_state_t  state
);
    import mas_pkg::*;

    mas_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (update_en) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

/* src/magnetic_angle_sensor_word_decoder_top.sv */
// Decoder for the 16-bit words of a rotating-magnet filament sensor. Each
// transaction on s_ carries either a received word or a framing-error event
// (s_tuser = 1) and yields exactly one status transaction on m_ with the
// decoded position change and the full sensor status. The block takes one
// transaction per cycle while m_tready does not stall it. A word passes
// through an input register and one decode stage that updates the sensor
// state and loads the result register, from which its status is presented
// on m_. Backpressure on m_tready stalls the decode stage; s_tready drops
// only when both registers are full and m_tready is low. Write
// cfg_wr_en/cfg_wr_data only while no transaction is in flight.
`include "magnetic_angle_sensor_word_decoder_top_defines.svh"

module magnetic_angle_sensor_word_decoder_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,   // switch_present
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,       // word
    input  logic          s_tuser,       // command
    output logic          m_tvalid,
    input  logic          m_tready,
    // angle[9:0], movement[20:10], sensor_error[21], error_code[29:22],
    // filament_absent[30], data_received[31], version[39:32],
    // magnitude[47:40], agc[55:48], parity_errors[87:56], framing_errors[119:88]
    output logic [119:0]  m_tdata,
    output logic          m_tuser        // position_valid
);
    import mas_pkg::*;

    logic               switch_present_reg;
    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic [WORD_W-1:0]  in_word_reg;
    logic               out_valid_reg;
    mas_result_t        out_result_reg;

    logic               advance;
    mas_state_t         st;
    mas_state_t         st_next;
    mas_result_t        result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            switch_present_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_word_reg <= s_tdata;
        end
    end

    mas_decode u_decode (
        .command        (in_cmd_reg),
        .word           (in_word_reg),
        .switch_present (switch_present_reg),
        .state          (st),
        .state_next     (st_next),
        .result         (result)
    );

    mas_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update_en  (advance),
        .state_next (st_next),
        .state      (st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.position_valid;
    assign m_tdata  = {
        out_result_reg.framing_errors,
        out_result_reg.parity_errors,
        out_result_reg.agc,
        out_result_reg.magnitude,
        out_result_reg.version,
        out_result_reg.data_received,
        out_result_reg.filament_absent,
        out_result_reg.error_code,
        out_result_reg.sensor_error,
        out_result_reg.movement,
        out_result_reg.angle
    };

    `MAS_ASSERT(a_framing_count_step, (advance && in_cmd_reg == CMD_FRAMING_ERROR) |=> (st.framing_count == $past(st.framing_count) + 32'd1), "framing counter did not advance by one")
    `MAS_ASSERT(a_movement_only_on_position, (out_valid_reg && !out_result_reg.position_valid) |-> (out_result_reg.movement == '0), "movement reported without a position word")
    `MAS_ASSERT(a_movement_range, out_valid_reg |-> ($signed(out_result_reg.movement) >= -11'sd511), "movement below half a turn backward")
    `MAS_ASSERT_ALWAYS(a_reset_state, !aresetn |=> (st.version == VERSION_ONE && st.parity_count == '0 && !out_valid_reg), "state not cleared by reset")

endmodule
